FILE: hw/rtl/flow_field_composition_assert.svh
// ----------------------------------------------------------------------------
// Flow field composition assertion macros
// Shorthand for the concurrent checks used in the flow field composition RTL.
// ----------------------------------------------------------------------------
`ifndef FLOW_FIELD_COMPOSITION_ASSERT_SVH
`define FLOW_FIELD_COMPOSITION_ASSERT_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define FFC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define FFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/ffc_pkg.sv
// ----------------------------------------------------------------------------
// Flow field composition package
// Shared widths, register indexes, request kinds, defaults and types.
// ----------------------------------------------------------------------------
package ffc_pkg;

	localparam int DEF_MAX_ROWS  = 256;
	localparam int DEF_MAX_COLS  = 256;
	localparam int DEF_FRAC_BITS = 5;

	localparam int POS_W  = 8;
	localparam int FLOW_W = 16;
	localparam int OUT_W  = 17;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd1;

	localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RST = 9'd256;

	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_COMPOSE = 1'b1;

	typedef struct packed {
		logic wr;
		logic rd;
	} ffc_mem_ctl_t;

endpackage

FILE: hw/rtl/ffc_req_if.sv
// ----------------------------------------------------------------------------
// Flow field composition request channel
// Valid/ready channel carrying one load or compose request per transfer.
// ----------------------------------------------------------------------------
interface ffc_req_if
	import ffc_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [POS_W-1:0]         row;
	logic [POS_W-1:0]         col;
	logic signed [FLOW_W-1:0] flow_u;
	logic signed [FLOW_W-1:0] flow_v;
	logic                     mask;

	modport source (output valid, kind, row, col, flow_u, flow_v, mask, input ready);
	modport sink   (input valid, kind, row, col, flow_u, flow_v, mask, output ready);
endinterface

FILE: hw/rtl/ffc_res_if.sv
// ----------------------------------------------------------------------------
// Flow field composition result channel
// Valid/ready channel carrying one composed flow vector per transfer.
// ----------------------------------------------------------------------------
interface ffc_res_if
	import ffc_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] out_u;
	logic signed [OUT_W-1:0] out_v;
	logic                    valid_res;

	modport source (output valid, out_u, out_v, valid_res, input ready);
	modport sink   (input valid, out_u, out_v, valid_res, output ready);
endinterface

FILE: hw/rtl/ffc_store.sv
// ----------------------------------------------------------------------------
// Flow field composition target store
// Single-port frame store of packed target flow vectors, registered read.
// ----------------------------------------------------------------------------
module ffc_store
	import ffc_pkg::*;
#(
	parameter int AW = 16
) (
	input  logic                    clk,
	input  ffc_mem_ctl_t            ctl,
	input  logic [AW-1:0]           addr,
	input  logic [2*FLOW_W-1:0]     wdata,
	output logic [2*FLOW_W-1:0]     rdata
);

	logic [2*FLOW_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (ctl.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: hw/rtl/flow_field_composition.sv
// ----------------------------------------------------------------------------
// Flow field composition
// Nearest-neighbor composition of a reference flow with a stored target flow.
// ----------------------------------------------------------------------------
// Requests arrive on req. A load request writes (flow_u, flow_v) into the
// target store at (row, col) and yields no result. A compose request rounds
// its flow to whole pixels, displaces (row, col), clamps into the frame and
// returns the rounded flow plus the stored target flow on result, with
// valid_res cleared when mask is low or the displaced pixel fell outside the frame.
// The frame size is set through cfg_we, cfg_idx and cfg_wdata; the user must
// write it only while idle, which the block does not enforce. The pipeline has
// five register stages and takes one request every cycle unless a stall backs
// up to req.ready. The single store port does at most one access per request.
// Each stage holds only while the stage after it is full and stalled, so
// requests keep entering while bubbles remain when the receiver stalls.
// Reset empties the pipeline and sets both frame sizes to 256; the store is
// not cleared, and a compose request must only read written entries.
// ----------------------------------------------------------------------------
module flow_field_composition
	import ffc_pkg::*;
#(
	parameter int MAX_ROWS  = DEF_MAX_ROWS,
	parameter int MAX_COLS  = DEF_MAX_COLS,
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ffc_req_if.sink               req,
	ffc_res_if.source             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	`include "flow_field_composition_assert.svh"

	localparam int RIW     = $clog2(MAX_ROWS);
	localparam int CIW     = $clog2(MAX_COLS);
	localparam int AW      = RIW + CIW;
	localparam int SIZE_W  = 13;
	localparam int MAG_W   = FLOW_W + 1;
	localparam int RU_W    = MAG_W + 1;
	localparam int PX_W    = RU_W + 1;
	localparam int ROW_RST = (MAX_ROWS < 256) ? MAX_ROWS : 256;
	localparam int COL_RST = (MAX_COLS < 256) ? MAX_COLS : 256;
	localparam logic [RIW-1:0] LAST_ROW_RST = RIW'(ROW_RST - 1);
	localparam logic [CIW-1:0] LAST_COL_RST = CIW'(COL_RST - 1);
	localparam logic [MAG_W-1:0] HALF = (FRAC_BITS == 0) ? '0 :
		MAG_W'(1 << ((FRAC_BITS == 0) ? 0 : FRAC_BITS - 1));

	logic [CFG_DATA_W-1:0] frame_height_q, frame_width_q;
	logic [RIW-1:0]        last_row_q;
	logic [CIW-1:0]        last_col_q;
	logic [SIZE_W-1:0]     h_ext, w_ext, h_clamp, w_clamp;

	logic en1, en2, en3, en4, en5;

	logic                  v_s1, kind_s1, mask_s1, in_store_s1, neg_u_s1, neg_v_s1;
	logic [POS_W-1:0]      row_s1, col_s1;
	logic [2*FLOW_W-1:0]   wdata_s1;
	logic [MAG_W-1:0]      mag_u_s1, mag_v_s1;

	logic                  v_s2, kind_s2, mask_s2, in_store_s2;
	logic [POS_W-1:0]      row_s2, col_s2;
	logic [2*FLOW_W-1:0]   wdata_s2;
	logic signed [RU_W-1:0] ru_s2, rv_s2;
	logic signed [PX_W-1:0] px_s2, py_s2;

	logic                  v_s3, kind_s3, in_store_s3, vres_s3;
	logic [RIW-1:0]        cy_s3;
	logic [CIW-1:0]        cx_s3;
	logic [2*FLOW_W-1:0]   wdata_s3;
	logic [OUT_W-1:0]      ru_s3, rv_s3;

	logic                  v_s4, vres_s4;
	logic [OUT_W-1:0]      ru_s4, rv_s4;
	logic [2*FLOW_W-1:0]   rdata_s4;

	logic                  v_s5, vres_s5;
	logic [OUT_W-1:0]      out_u_s5, out_v_s5;

	logic [MAG_W-1:0]      ext_u, ext_v, abs_u, abs_v, mag_u, mag_v;
	logic                  in_store;
	logic signed [RU_W-1:0] ru_c, rv_c;
	logic [SIZE_W-1:0]     row_ext, col_ext;
	logic                  px_lo, px_hi, py_lo, py_hi;
	logic [RIW-1:0]        cy_c;
	logic [CIW-1:0]        cx_c;
	ffc_mem_ctl_t          mem_ctl;
	logic [AW-1:0]         mem_addr;

	// Frame size registers and their clamped last indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_height_q <= FRAME_SIZE_RST;
			frame_width_q  <= FRAME_SIZE_RST;
			last_row_q     <= LAST_ROW_RST;
			last_col_q     <= LAST_COL_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
					REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				endcase
			end
			last_row_q <= RIW'(h_clamp - SIZE_W'(1));
			last_col_q <= CIW'(w_clamp - SIZE_W'(1));
		end
	end

	always_comb begin
		h_ext = SIZE_W'(frame_height_q);
		w_ext = SIZE_W'(frame_width_q);
		if (h_ext == '0) begin
			h_clamp = SIZE_W'(1);
		end else if (h_ext > SIZE_W'(MAX_ROWS)) begin
			h_clamp = SIZE_W'(MAX_ROWS);
		end else begin
			h_clamp = h_ext;
		end
		if (w_ext == '0) begin
			w_clamp = SIZE_W'(1);
		end else if (w_ext > SIZE_W'(MAX_COLS)) begin
			w_clamp = SIZE_W'(MAX_COLS);
		end else begin
			w_clamp = w_ext;
		end
	end

	// Stage enables: a stage loads when it is empty or the next one loads.
	assign en5 = !v_s5 || result.ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	// Stage 1: magnitude rounded half away from zero.
	always_comb begin
		ext_u    = {req.flow_u[FLOW_W-1], req.flow_u};
		ext_v    = {req.flow_v[FLOW_W-1], req.flow_v};
		abs_u    = req.flow_u[FLOW_W-1] ? (~ext_u + MAG_W'(1)) : ext_u;
		abs_v    = req.flow_v[FLOW_W-1] ? (~ext_v + MAG_W'(1)) : ext_v;
		mag_u    = (abs_u + HALF) >> FRAC_BITS;
		mag_v    = (abs_v + HALF) >> FRAC_BITS;
		in_store = (32'(req.row) < MAX_ROWS) && (32'(req.col) < MAX_COLS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			kind_s1     <= req.kind;
			mask_s1     <= req.mask;
			in_store_s1 <= in_store;
			row_s1      <= req.row;
			col_s1      <= req.col;
			wdata_s1    <= {req.flow_v, req.flow_u};
			neg_u_s1    <= req.flow_u[FLOW_W-1];
			neg_v_s1    <= req.flow_v[FLOW_W-1];
			mag_u_s1    <= mag_u;
			mag_v_s1    <= mag_v;
		end
	end

	// Stage 2: signed whole-pixel flow and displaced position.
	always_comb begin
		ru_c = neg_u_s1 ? -$signed({1'b0, mag_u_s1}) : $signed({1'b0, mag_u_s1});
		rv_c = neg_v_s1 ? -$signed({1'b0, mag_v_s1}) : $signed({1'b0, mag_v_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			kind_s2     <= kind_s1;
			mask_s2     <= mask_s1;
			in_store_s2 <= in_store_s1;
			row_s2      <= row_s1;
			col_s2      <= col_s1;
			wdata_s2    <= wdata_s1;
			ru_s2       <= ru_c;
			rv_s2       <= rv_c;
			px_s2       <= $signed(PX_W'(col_s1)) + PX_W'(ru_c);
			py_s2       <= $signed(PX_W'(row_s1)) + PX_W'(rv_c);
		end
	end

	// Stage 3: frame test, clamp and store address.
	always_comb begin
		row_ext = SIZE_W'(row_s2);
		col_ext = SIZE_W'(col_s2);
		px_lo   = px_s2[PX_W-1];
		py_lo   = py_s2[PX_W-1];
		px_hi   = !px_lo && (px_s2[PX_W-2:0] > (PX_W-1)'(last_col_q));
		py_hi   = !py_lo && (py_s2[PX_W-2:0] > (PX_W-1)'(last_row_q));
		if (kind_s2 == KIND_LOAD) begin
			cx_c = col_ext[CIW-1:0];
			cy_c = row_ext[RIW-1:0];
		end else begin
			cx_c = px_lo ? '0 : (px_hi ? last_col_q : px_s2[CIW-1:0]);
			cy_c = py_lo ? '0 : (py_hi ? last_row_q : py_s2[RIW-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			kind_s3     <= kind_s2;
			in_store_s3 <= in_store_s2;
			vres_s3     <= mask_s2 && !(px_lo || px_hi || py_lo || py_hi);
			cx_s3       <= cx_c;
			cy_s3       <= cy_c;
			wdata_s3    <= wdata_s2;
			ru_s3       <= ru_s2[OUT_W-1:0];
			rv_s3       <= rv_s2[OUT_W-1:0];
		end
	end

	// Stage 4: at most one store access per request, read data registered.
	assign mem_ctl.wr = en4 && v_s3 && (kind_s3 == KIND_LOAD) && in_store_s3;
	assign mem_ctl.rd = en4 && v_s3 && (kind_s3 == KIND_COMPOSE);
	assign mem_addr   = {cy_s3, cx_s3};

	ffc_store #(
		.AW(AW)
	) u_store (
		.clk   (clk),
		.ctl   (mem_ctl),
		.addr  (mem_addr),
		.wdata (wdata_s3),
		.rdata (rdata_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3 && (kind_s3 == KIND_COMPOSE);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			vres_s4 <= vres_s3;
			ru_s4   <= ru_s3;
			rv_s4   <= rv_s3;
		end
	end

	// Stage 5: output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			vres_s5  <= vres_s4;
			out_u_s5 <= (ru_s4 << FRAC_BITS) +
				{rdata_s4[FLOW_W-1], rdata_s4[FLOW_W-1:0]};
			out_v_s5 <= (rv_s4 << FRAC_BITS) +
				{rdata_s4[2*FLOW_W-1], rdata_s4[2*FLOW_W-1:FLOW_W]};
		end
	end

	assign result.valid     = v_s5;
	assign result.out_u     = $signed(out_u_s5);
	assign result.out_v     = $signed(out_v_s5);
	assign result.valid_res = vres_s5;

	`FFC_ASSERT_NOW(a_ready_when_out_empty, !v_s5, req.ready,
		"request refused with empty output")
	`FFC_ASSERT_NEXT(a_read_data_held, v_s4 && !en5, $stable(rdata_s4),
		"store read data lost in stall")
	`FFC_ASSERT_NOW(a_clamp_in_frame, v_s3 && (kind_s3 == KIND_COMPOSE),
		(cy_s3 <= last_row_q) && (cx_s3 <= last_col_q), "compose read outside frame")

endmodule

FILE: dv/ffc_tb_pkg.sv
// ----------------------------------------------------------------------------
// Flow field composition testbench helpers
// Pixel rounding and frame clamping shared by stimulus and result checking.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffc_tb_pkg;
	import ffc_pkg::*;

	localparam int ONE_PIXEL = 1 << DEF_FRAC_BITS;
	localparam int HALF_PIXEL = ONE_PIXEL >> 1;

	function automatic int to_whole_pixels(input logic signed [FLOW_W-1:0] f);
		int a;
		a = f;
		if (a >= 0)
			return (a + HALF_PIXEL) >>> DEF_FRAC_BITS;
		return -((-a + HALF_PIXEL) >>> DEF_FRAC_BITS);
	endfunction

	function automatic int frame_extent(input logic [CFG_DATA_W-1:0] size, input int limit);
		if (size == '0)
			return 1;
		if (int'(size) > limit)
			return limit;
		return int'(size);
	endfunction

	function automatic int clamp_to(input int x, input int hi);
		if (x < 0)
			return 0;
		if (x > hi)
			return hi;
		return x;
	endfunction

endpackage

FILE: dv/ffc_result_check.sv
// ----------------------------------------------------------------------------
// Flow field composition result checker
// Watches the request, result and register ports, keeps its own copy of the
// target store and frame size, predicts every composed vector and compares
// each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffc_result_check
	import ffc_pkg::*;
	import ffc_tb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ffc_req_if                    req,
	ffc_res_if                    res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    pending,
	output int                    checked,
	output int                    fails
);

	typedef struct packed {
		logic signed [OUT_W-1:0] out_u;
		logic signed [OUT_W-1:0] out_v;
		logic                    valid_res;
	} composed_t;

	localparam int STORE_DEPTH = DEF_MAX_ROWS * DEF_MAX_COLS;

	logic [2*FLOW_W-1:0]   target_store [STORE_DEPTH];
	logic [CFG_DATA_W-1:0] frame_rows;
	logic [CFG_DATA_W-1:0] frame_cols;
	composed_t             composed_q [$];

	initial begin
		pending = 0;
		checked = 0;
		fails = 0;
		frame_rows = FRAME_SIZE_RST;
		frame_cols = FRAME_SIZE_RST;
	end

	function automatic composed_t compose_flow(input logic [POS_W-1:0] r, c,
			input logic signed [FLOW_W-1:0] fu, fv, input logic m);
		composed_t           vec;
		int                  ru, rv, px, py, h, w;
		logic [2*FLOW_W-1:0] entry;
		ru = to_whole_pixels(fu);
		rv = to_whole_pixels(fv);
		px = int'(c) + ru;
		py = int'(r) + rv;
		h = frame_extent(frame_rows, DEF_MAX_ROWS);
		w = frame_extent(frame_cols, DEF_MAX_COLS);
		entry = target_store[clamp_to(py, h - 1) * DEF_MAX_COLS + clamp_to(px, w - 1)];
		vec.out_u = OUT_W'(ru * ONE_PIXEL + int'($signed(entry[FLOW_W-1:0])));
		vec.out_v = OUT_W'(rv * ONE_PIXEL + int'($signed(entry[2*FLOW_W-1:FLOW_W])));
		vec.valid_res = (px < 0 || px >= w || py < 0 || py >= h) ? 1'b0 : m;
		return vec;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		composed_t want;
		if (!arst_n) begin
			frame_rows = FRAME_SIZE_RST;
			frame_cols = FRAME_SIZE_RST;
			composed_q.delete();
		end else begin
			if (res.valid && res.ready) begin
				checked++;
				if (composed_q.size() == 0) begin
					$error("result arrived with no compose request outstanding");
					fails++;
				end else begin
					want = composed_q.pop_front();
					if (res.out_u !== want.out_u) begin
						$error("out_u: expected %0d, got %0d", want.out_u, res.out_u);
						fails++;
					end
					if (res.out_v !== want.out_v) begin
						$error("out_v: expected %0d, got %0d", want.out_v, res.out_v);
						fails++;
					end
					if (res.valid_res !== want.valid_res) begin
						$error("valid_res: expected %0d, got %0d", want.valid_res,
							res.valid_res);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx)
					REG_FRAME_HEIGHT: frame_rows = cfg_wdata;
					REG_FRAME_WIDTH: frame_cols = cfg_wdata;
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				if (req.kind == KIND_LOAD)
					target_store[int'(req.row) * DEF_MAX_COLS + int'(req.col)] =
						{req.flow_v, req.flow_u};
				else
					composed_q.push_back(compose_flow(req.row, req.col, req.flow_u,
						req.flow_v, req.mask));
			end
		end
		pending = composed_q.size();
	end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Flow field composition testbench
// Drives load and compose requests with random gaps and result stalls,
// steps the frame size through its extremes between phases, and reports the
// verdict from the result checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import ffc_pkg::*;
	import ffc_tb_pkg::*;

	localparam int PHASES = 7;
	localparam int PHASE_ITEMS = 90;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    pending;
	int                    checked;
	int                    fails;
	int                    load_count;
	int                    compose_count;
	logic [CFG_DATA_W-1:0] rows_set;
	logic [CFG_DATA_W-1:0] cols_set;
	bit                    written [DEF_MAX_ROWS * DEF_MAX_COLS];
	bit                    calm;

	ffc_req_if req_ch();
	ffc_res_if res_ch();

	flow_field_composition dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	ffc_result_check result_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.checked   (checked),
		.fails     (fails)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : result_stall
		int hold;
		int roll;
		hold = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (calm) begin
				res_ch.ready = 1'b1;
			end else begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					res_ch.ready = 1'b1;
					hold = $urandom_range(0, 8);
				end else if (roll < 92) begin
					res_ch.ready = 1'b0;
					hold = $urandom_range(0, 2);
				end else begin
					res_ch.ready = 1'b0;
					hold = $urandom_range(10, 40);
				end
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [FLOW_W-1:0] pick_flow();
		int roll;
		int k;
		roll = $urandom_range(0, 99);
		k = int'($urandom_range(0, 8)) - 4;
		if (roll < 55)
			return FLOW_W'(int'($urandom_range(0, 12 * ONE_PIXEL)) - 6 * ONE_PIXEL);
		if (roll < 70)
			return FLOW_W'(k * ONE_PIXEL + ($urandom_range(0, 1) ? HALF_PIXEL : -HALF_PIXEL));
		return FLOW_W'($urandom);
	endfunction

	task automatic push_request(input logic kind, input logic [POS_W-1:0] r, c,
			input logic signed [FLOW_W-1:0] fu, fv, input logic m);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.kind = kind;
		req_ch.row = r;
		req_ch.col = c;
		req_ch.flow_u = fu;
		req_ch.flow_v = fv;
		req_ch.mask = m;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic push_load(input logic [POS_W-1:0] r, c,
			input logic signed [FLOW_W-1:0] fu, fv, input logic m);
		push_request(KIND_LOAD, r, c, fu, fv, m);
		written[int'(r) * DEF_MAX_COLS + int'(c)] = 1'b1;
		load_count++;
	endtask

	// A compose request may only read a written entry, so the landing pixel
	// is loaded first when it has never been written.
	task automatic push_compose(input logic [POS_W-1:0] r, c,
			input logic signed [FLOW_W-1:0] fu, fv, input logic m);
		int cx, cy;
		cx = clamp_to(int'(c) + to_whole_pixels(fu), frame_extent(cols_set, DEF_MAX_COLS) - 1);
		cy = clamp_to(int'(r) + to_whole_pixels(fv), frame_extent(rows_set, DEF_MAX_ROWS) - 1);
		if (!written[cy * DEF_MAX_COLS + cx])
			push_load(POS_W'(cy), POS_W'(cx), FLOW_W'($urandom), FLOW_W'($urandom),
				1'($urandom_range(0, 1)));
		push_request(KIND_COMPOSE, r, c, fu, fv, m);
		compose_count++;
	endtask

	task automatic settle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_FRAME_HEIGHT)
			rows_set = data;
		else
			cols_set = data;
	endtask

	task automatic run_random(input int n);
		int h, w, roll;
		logic [POS_W-1:0] r, c;
		h = frame_extent(rows_set, DEF_MAX_ROWS);
		w = frame_extent(cols_set, DEF_MAX_COLS);
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 99) < 70) begin
				r = POS_W'($urandom_range(0, h - 1));
				c = POS_W'($urandom_range(0, w - 1));
			end else begin
				r = POS_W'($urandom);
				c = POS_W'($urandom);
			end
			if (roll < 35)
				push_load(r, c, FLOW_W'($urandom), FLOW_W'($urandom),
					1'($urandom_range(0, 1)));
			else
				push_compose(r, c, pick_flow(), pick_flow(), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] h_next, w_next;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_LOAD;
		req_ch.row = '0;
		req_ch.col = '0;
		req_ch.flow_u = '0;
		req_ch.flow_v = '0;
		req_ch.mask = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_FRAME_HEIGHT;
		cfg_wdata = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		rows_set = FRAME_SIZE_RST;
		cols_set = FRAME_SIZE_RST;
		load_count = 0;
		compose_count = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		push_load(8'd0, 8'd0, 16'sh7FFF, 16'sh8000, 1'b0);
		push_load(8'hFF, 8'hFF, 16'sh8000, 16'sh7FFF, 1'b1);
		push_load(8'd0, 8'hFF, 16'sd0, -16'sd1, 1'b0);
		push_load(8'hFF, 8'd0, -16'sd1, 16'sd0, 1'b0);
		push_compose(8'd0, 8'd0, 16'sd0, 16'sd0, 1'b1);
		push_compose(8'd0, 8'd0, 16'sd0, 16'sd0, 1'b0);
		push_compose(8'hFF, 8'hFF, FLOW_W'(HALF_PIXEL), FLOW_W'(HALF_PIXEL), 1'b1);
		push_compose(8'hFF, 8'hFF, FLOW_W'(HALF_PIXEL - 1), FLOW_W'(1 - HALF_PIXEL), 1'b1);
		push_compose(8'd0, 8'd0, FLOW_W'(-HALF_PIXEL), FLOW_W'(-HALF_PIXEL), 1'b1);
		push_compose(8'd128, 8'd128, 16'sh7FFF, 16'sh8000, 1'b1);
		push_compose(8'd128, 8'd128, 16'sh8000, 16'sh7FFF, 1'b1);
		push_compose(8'd0, 8'hFF, FLOW_W'(-3 * HALF_PIXEL), FLOW_W'(3 * HALF_PIXEL), 1'b1);
		push_load(8'd0, 8'd0, 16'sh1234, -16'sh0ABC, 1'b1);
		push_compose(8'd0, 8'd1, FLOW_W'(-ONE_PIXEL), 16'sd0, 1'b1);
		push_compose(8'd7, 8'd9, 16'sd0, 16'sd0, 1'b1);
		push_compose(8'd200, 8'd3, FLOW_W'(-5 * ONE_PIXEL), FLOW_W'(2 * ONE_PIXEL), 1'b0);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin h_next = 9'd1; w_next = 9'd1; end
				1: begin h_next = 9'd0; w_next = 9'd511; end
				2: begin h_next = 9'd511; w_next = 9'd0; end
				3: begin h_next = 9'd12; w_next = 9'd9; end
				4: begin h_next = 9'd300; w_next = 9'd40; end
				5: begin h_next = 9'd256; w_next = 9'd256; end
				default: begin
					h_next = CFG_DATA_W'($urandom_range(1, 256));
					w_next = CFG_DATA_W'($urandom_range(1, 256));
				end
			endcase
			write_reg(REG_FRAME_HEIGHT, h_next);
			write_reg(REG_FRAME_WIDTH, w_next);
			calm = (p == 5);
			run_random(PHASE_ITEMS);
			settle();
		end

		$display("Sent %0d load and %0d compose requests across %0d frame sizes.",
			load_count, compose_count, PHASES + 1);
		$display("Compared %0d composed vectors against prediction.", checked);
		if (fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ffc_pkg.sv
hw/rtl/ffc_req_if.sv
hw/rtl/ffc_res_if.sv
hw/rtl/ffc_store.sv
hw/rtl/flow_field_composition.sv
dv/ffc_tb_pkg.sv
dv/ffc_result_check.sv
dv/tb_top.sv
